[hw/rtl/hash_table_probe_insert_delete_top_defines.svh]
// ----------------------------------------------------------------------------
// hash table probe/insert/delete assertion macros
// concurrent assertion helpers, clocked by clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef HASH_TABLE_PROBE_INSERT_DELETE_TOP_DEFINES_SVH
`define HASH_TABLE_PROBE_INSERT_DELETE_TOP_DEFINES_SVH

// same-cycle implication
`define HTPID_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define HTPID_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/htpid_pkg.sv]
// ----------------------------------------------------------------------------
// htpid_pkg
// shared types and constants of the open-addressed key table
// ----------------------------------------------------------------------------
package htpid_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 128;
   localparam int KEY_BITS_DEFAULT    = 16;

   localparam int CAP_BITS    = 8;
   localparam int OCC_BITS    = 8;
   localparam int STATUS_BITS = 3;
   localparam int DIGIT_BITS  = 4;

   localparam logic [CAP_BITS-1:0] FIRST_STEP     = 8'd4;
   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 8'd67;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_OVERWROTE = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_DELETED   = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ_HOME,
      ST_CHECK_HOME,
      ST_READ_PROBE,
      ST_CHECK_PROBE,
      ST_DELIVER
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_DIV,
      CMD_ADVANCE,
      CMD_INSERT,
      CMD_OVERWRITE,
      CMD_DELETE,
      CMD_FULL,
      CMD_MISS,
      CMD_SEND
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type op;
      logic       req_ready;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_delete;
      logic div_last;
      logic slot_valid;
      logic key_match;
      logic count_full;
      logic next_at_home;
      logic rsp_free;
   } dp_status_type;

endpackage

[hw/rtl/htpid_ctrl.sv]
// ----------------------------------------------------------------------------
// htpid_ctrl
// sequencer for one request: accept, divide, probe, commit, deliver
// ----------------------------------------------------------------------------
module htpid_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  htpid_pkg::dp_status_type status,
   output htpid_pkg::ctrl_cmd_type  cmd
);
   import htpid_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      hit;

   assign hit = status.slot_valid && status.key_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_READ_HOME;
         end
         ST_READ_HOME: state_in = ST_CHECK_HOME;
         ST_CHECK_HOME: begin
            if (status.is_delete || !status.slot_valid || hit || status.next_at_home) begin
               state_in = ST_DELIVER;
            end else begin
               state_in = ST_READ_PROBE;
            end
         end
         ST_READ_PROBE: state_in = ST_CHECK_PROBE;
         ST_CHECK_PROBE: begin
            if (!status.slot_valid || hit || status.next_at_home) begin
               state_in = ST_DELIVER;
            end else begin
               state_in = ST_READ_PROBE;
            end
         end
         ST_DELIVER: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op        = CMD_NONE;
      cmd.req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) cmd.op = CMD_LOAD;
         end
         ST_DIVIDE: cmd.op = CMD_DIV;
         ST_READ_HOME, ST_READ_PROBE: cmd.op = CMD_NONE;
         ST_CHECK_HOME: begin
            if (status.is_delete) begin
               cmd.op = hit ? CMD_DELETE : CMD_MISS;
            end else if (!status.slot_valid) begin
               // empty home slot still refused once the count reaches capacity
               cmd.op = status.count_full ? CMD_FULL : CMD_INSERT;
            end else if (hit) begin
               cmd.op = CMD_OVERWRITE;
            end else begin
               cmd.op = status.next_at_home ? CMD_FULL : CMD_ADVANCE;
            end
         end
         ST_CHECK_PROBE: begin
            if (!status.slot_valid) begin
               cmd.op = CMD_INSERT;
            end else if (hit) begin
               cmd.op = CMD_OVERWRITE;
            end else begin
               cmd.op = status.next_at_home ? CMD_FULL : CMD_ADVANCE;
            end
         end
         ST_DELIVER: begin
            if (status.rsp_free) cmd.op = CMD_SEND;
         end
         default: cmd.op = CMD_NONE;
      endcase
   end

endmodule

[hw/rtl/htpid_datapath.sv]
// ----------------------------------------------------------------------------
// htpid_datapath
// capacity register, remainder unit, probe index, slot store, result register
// ----------------------------------------------------------------------------
module htpid_datapath #(
   parameter int TABLE_SLOTS = htpid_pkg::TABLE_SLOTS_DEFAULT,
   parameter int KEY_BITS    = htpid_pkg::KEY_BITS_DEFAULT,
   parameter int SLOT_BITS   = $clog2(TABLE_SLOTS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  htpid_pkg::ctrl_cmd_type              cmd,
   input  logic                                req_valid,
   input  logic                                req_opcode,
   input  logic [KEY_BITS-1:0]                 req_key,
   input  logic                                csr_valid,
   input  logic [htpid_pkg::CAP_BITS-1:0]      csr_data,
   input  logic                                rsp_ready,
   output htpid_pkg::dp_status_type             status,
   output logic                                rsp_valid,
   output logic [htpid_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [SLOT_BITS-1:0]                rsp_slot,
   output logic [htpid_pkg::OCC_BITS-1:0]      rsp_occupancy
);
   import htpid_pkg::*;

   // capacity never exceeds 255, so only the low slots can ever be reached
   localparam int USED_SLOTS = (TABLE_SLOTS < 255) ? TABLE_SLOTS : 255;
   localparam int IDX_BITS   = $clog2(USED_SLOTS);
   localparam int DIGITS     = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int KEY_PAD    = DIGITS * DIGIT_BITS;
   localparam int CNT_BITS   = $clog2(DIGITS);

   function automatic logic [CAP_BITS-1:0] first_step(input logic [CAP_BITS-1:0] cap);
      logic [CAP_BITS-1:0] s;
      s = FIRST_STEP;
      if (cap == 8'd3) begin
         s = 8'd1;
      end else if (cap <= FIRST_STEP) begin
         s = '0;
      end
      return s;
   endfunction

   function automatic logic [CAP_BITS-1:0] rem_digit(input logic [CAP_BITS-1:0] rem,
                                                     input logic [DIGIT_BITS-1:0] dig,
                                                     input logic [CAP_BITS-1:0] cap);
      logic [CAP_BITS:0]   r;
      logic [CAP_BITS-1:0] acc;
      acc = rem;
      for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
         r = {acc, dig[i]};
         if (r >= {1'b0, cap}) r = r - {1'b0, cap};
         acc = r[CAP_BITS-1:0];
      end
      return acc;
   endfunction

   logic [CAP_BITS-1:0]   cap_ff;
   logic [CAP_BITS-1:0]   eff_cap;
   logic [CAP_BITS-1:0]   cap_lo;

   logic [KEY_BITS-1:0]   key_ff;
   logic                  op_ff;
   logic [KEY_PAD-1:0]    key_sh_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [CAP_BITS-1:0]   rem_ff;
   logic [CAP_BITS-1:0]   rem_in;

   logic [IDX_BITS-1:0]   home_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [CAP_BITS-1:0]   step_ff;
   logic [CAP_BITS:0]     probe_sum;
   logic [CAP_BITS:0]     step_sum;
   logic [IDX_BITS-1:0]   next_idx;
   logic [CAP_BITS-1:0]   next_step;

   logic [USED_SLOTS-1:0] valid_ff;
   logic [KEY_BITS-1:0]   key_mem [USED_SLOTS];
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic                  valid_rd_ff;
   logic                  key_wr;

   logic [OCC_BITS-1:0]   count_ff;
   status_type            res_status_ff;
   logic [SLOT_BITS-1:0]  res_slot_ff;

   logic                  rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [SLOT_BITS-1:0]  rsp_slot_ff;
   logic [OCC_BITS-1:0]   rsp_occ_ff;
   logic                  rsp_free;

   // capacity zero acts as one, capacity above the store as the store size
   always_comb begin
      cap_lo  = (cap_ff == '0) ? 8'd1 : cap_ff;
      eff_cap = cap_lo;
      if (32'(cap_lo) > TABLE_SLOTS) eff_cap = CAP_BITS'(TABLE_SLOTS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else if (csr_valid) begin
         cap_ff <= csr_data;
      end
   end

   assign rem_in = rem_digit(rem_ff, key_sh_ff[KEY_PAD-1 -: DIGIT_BITS], eff_cap);

   // home and step are both below capacity, one subtract folds the sum back
   always_comb begin
      probe_sum = {1'b0, CAP_BITS'(home_ff)} + {1'b0, step_ff};
      if (probe_sum >= {1'b0, eff_cap}) probe_sum = probe_sum - {1'b0, eff_cap};
      next_idx  = IDX_BITS'(probe_sum);
      step_sum  = {1'b0, step_ff} + 9'd1;
      next_step = (step_sum == {1'b0, eff_cap}) ? '0 : step_sum[CAP_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_LOAD: begin
            key_ff    <= req_key;
            op_ff     <= req_opcode;
            key_sh_ff <= KEY_PAD'(req_key);
            rem_ff    <= '0;
         end
         CMD_DIV: begin
            rem_ff    <= rem_in;
            key_sh_ff <= key_sh_ff << DIGIT_BITS;
            home_ff   <= IDX_BITS'(rem_in);
            idx_ff    <= IDX_BITS'(rem_in);
            step_ff   <= first_step(eff_cap);
         end
         CMD_ADVANCE: begin
            idx_ff  <= next_idx;
            step_ff <= next_step;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.op == CMD_LOAD) begin
         cnt_ff <= '0;
      end else if (cmd.op == CMD_DIV) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign key_wr = (cmd.op == CMD_INSERT) || (cmd.op == CMD_OVERWRITE);

   always_ff @(posedge clock) begin
      if (key_wr) key_mem[idx_ff] <= key_ff;
      key_rd_ff <= key_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         valid_rd_ff <= 1'b0;
      end else begin
         valid_rd_ff <= valid_ff[idx_ff];
         if (cmd.op == CMD_INSERT) begin
            valid_ff[idx_ff] <= 1'b1;
         end else if (cmd.op == CMD_DELETE) begin
            valid_ff[idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.op == CMD_INSERT && count_ff != '1) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.op == CMD_DELETE && count_ff != '0) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_INSERT: begin
            res_status_ff <= STATUS_INSERTED;
            res_slot_ff   <= SLOT_BITS'(idx_ff);
         end
         CMD_OVERWRITE: begin
            res_status_ff <= STATUS_OVERWROTE;
            res_slot_ff   <= SLOT_BITS'(idx_ff);
         end
         CMD_DELETE: begin
            res_status_ff <= STATUS_DELETED;
            res_slot_ff   <= SLOT_BITS'(idx_ff);
         end
         CMD_FULL: begin
            res_status_ff <= STATUS_FULL;
            res_slot_ff   <= '0;
         end
         CMD_MISS: begin
            res_status_ff <= STATUS_NOT_FOUND;
            res_slot_ff   <= '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == CMD_SEND) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_SEND) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_occ_ff    <= count_ff;
      end
   end

   assign status.req_valid    = req_valid;
   assign status.is_delete    = (op_ff == OP_DELETE);
   assign status.div_last     = (cnt_ff == CNT_BITS'(DIGITS - 1));
   assign status.slot_valid   = valid_rd_ff;
   assign status.key_match    = (key_rd_ff == key_ff);
   assign status.count_full   = (count_ff >= eff_cap);
   assign status.next_at_home = (next_idx == home_ff);
   assign status.rsp_free     = rsp_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

[hw/rtl/hash_table_probe_insert_delete_top.sv]
// ----------------------------------------------------------------------------
// hash_table_probe_insert_delete_top
// open-addressed key table taking insert and delete requests
// ----------------------------------------------------------------------------
// usage:
//   req channel: one transaction per request, key in req_tdata, opcode in
//     req_tuser (0 insert, 1 delete). req_tready is high only while the block
//     is free to start a new request.
//   rsp channel: one transaction per request, status, slot and occupancy
//     in rsp_tdata, in request order.
//   csr channel: writes the 8-bit capacity (hash modulus); always ready.
//     write it only between requests.
//   timing: the request is accepted, then the remainder unit takes the key
//     one 4-bit digit at a time, most significant first, then each slot
//     inspected is read from the slot store and then compared, then the
//     result goes into the output register. up to capacity slots are
//     inspected per request. the remainder unit and the single-port slot
//     store set this sequence.
//   the output register holds a result while rsp_tready is low; the block
//     then finishes the request in hand and waits before taking another.
//   reset: synchronous, clears all slot valid bits at once, the occupancy
//     and the response valid flag, and sets capacity to 67.
// ----------------------------------------------------------------------------
`include "hash_table_probe_insert_delete_top_defines.svh"

module hash_table_probe_insert_delete_top #(
   parameter int TABLE_SLOTS = htpid_pkg::TABLE_SLOTS_DEFAULT,
   parameter int KEY_BITS    = htpid_pkg::KEY_BITS_DEFAULT,
   parameter int SLOT_BITS   = $clog2(TABLE_SLOTS),
   parameter int REQ_BITS    = ((KEY_BITS + 7) / 8) * 8,
   parameter int RSP_BITS    = ((htpid_pkg::STATUS_BITS + SLOT_BITS + htpid_pkg::OCC_BITS + 7)
                               / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [REQ_BITS-1:0]            req_tdata,   // key
   input  logic [0:0]                     req_tuser,   // opcode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [RSP_BITS-1:0]            rsp_tdata,   // status, slot, occupancy
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [htpid_pkg::CAP_BITS-1:0] csr_data     // capacity
);
   import htpid_pkg::*;

   ctrl_cmd_type          cmd;
   dp_status_type         status;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [SLOT_BITS-1:0]  rsp_slot;
   logic [OCC_BITS-1:0]   rsp_occupancy;

   htpid_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   htpid_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_BITS    (KEY_BITS),
      .SLOT_BITS   (SLOT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_valid     (req_tvalid),
      .req_opcode    (req_tuser[0]),
      .req_key       (KEY_BITS'(req_tdata)),
      .csr_valid     (csr_valid),
      .csr_data      (csr_data),
      .rsp_ready     (rsp_tready),
      .status        (status),
      .rsp_valid     (rsp_tvalid),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_occupancy (rsp_occupancy)
   );

   assign req_tready = cmd.req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = RSP_BITS'({rsp_occupancy, rsp_slot, rsp_status});

   // one request in hand at a time
   `HTPID_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

   // a new key only goes into a slot that read back empty
   `HTPID_ASSERT_SAME(a_insert_empty, cmd.op == CMD_INSERT, !status.slot_valid)

   // full and not-found results carry slot zero
   `HTPID_ASSERT_SAME(a_miss_slot_zero,
      rsp_tvalid && (rsp_status == STATUS_FULL || rsp_status == STATUS_NOT_FOUND),
      rsp_slot == '0)

endmodule
